// ----- hdl/assert_macros.svh -----
// Assertion macros for the heap allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside of reset.
`define FFHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside of reset.
`define FFHA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_NEVER(lbl, expr, msg)
`endif
`endif

// ----- hdl/ffha_pkg.sv -----
// Shared types, action codes and default sizes of the heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int DEF_HEAP_BYTES      = 65536;
    localparam int DEF_PAGE_BYTES      = 4096;
    localparam int DEF_HEADER_BYTES    = 20;
    localparam int DEF_MIN_BLOCK_BYTES = 16;
    localparam int DEF_MAX_BLOCKS      = 64;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [16:0] request_size;
        logic [15:0] data_offset;
    } in_item_t;

    typedef struct packed {
        logic [15:0] result_offset;
        logic        failed;
        logic [4:0]  pages_added;
        logic [16:0] block_bytes;
    } out_item_t;

endpackage

// ----- hdl/ffha_mem.sv -----
// Block table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ffha_mem #(
    parameter int DEPTH = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int EW    = 35
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [EW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [EW-1:0]            wr_data
);
    logic [EW-1:0] mem [DEPTH];

    // write entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read entry, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- hdl/ffha_ctrl.sv -----
// Sequencer that searches, grows, splits, merges and shifts the block table.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ffha_ctrl #(
    parameter int HEAP_BYTES      = ffha_pkg::DEF_HEAP_BYTES,
    parameter int PAGE_BYTES      = ffha_pkg::DEF_PAGE_BYTES,
    parameter int HEADER_BYTES    = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MIN_BLOCK_BYTES = ffha_pkg::DEF_MIN_BLOCK_BYTES,
    parameter int MAX_BLOCKS      = ffha_pkg::DEF_MAX_BLOCKS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cmd_valid,
    output logic                                     cmd_ready,
    input  ffha_pkg::in_item_t                       cmd,
    output logic                                     done,
    input  logic                                     slot_free,
    output ffha_pkg::out_item_t                      result,
    output logic                                     rd_en,
    output logic [$clog2(MAX_BLOCKS)-1:0]            rd_addr,
    input  logic [2*$clog2(HEAP_BYTES+1):0]          rd_data,
    output logic                                     wr_en,
    output logic [$clog2(MAX_BLOCKS)-1:0]            wr_addr,
    output logic [2*$clog2(HEAP_BYTES+1):0]          wr_data
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int XW = CW + 1;
    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int WW = ((AW > 17) ? AW : 17) + 2;
    localparam int PS = $clog2(PAGE_BYTES);

    typedef struct packed {
        logic          free;
        logic [AW-1:0] size;
        logic [AW-1:0] start;
    } entry_t;

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_SCAN_RD    = 13'b0000000000010,
        S_SCAN_CHK   = 13'b0000000000100,
        S_GROW       = 13'b0000000001000,
        S_NEXT_RD    = 13'b0000000010000,
        S_NEXT_CHK   = 13'b0000000100000,
        S_MERGE_PREV = 13'b0000001000000,
        S_PREV_WR    = 13'b0000010000000,
        S_SHIFT_RD   = 13'b0000100000000,
        S_SHIFT_WR   = 13'b0001000000000,
        S_WR_TAIL    = 13'b0010000000000,
        S_WR_HEAD    = 13'b0100000000000,
        S_DONE       = 13'b1000000000000
    } state_t;

    state_t        state_reg, state_next;
    state_t        ret_reg, ret_next;
    logic          up_reg, up_next;
    logic [1:0]    op_reg, op_next;
    logic [16:0]   req_reg, req_next;
    logic [15:0]   off_reg, off_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic [CW-1:0] stop_reg, stop_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] brk_reg, brk_next;
    entry_t        head_reg, head_next;
    entry_t        tail_reg, tail_next;
    entry_t        prev_reg, prev_next;
    out_item_t     res_reg, res_next;

    entry_t        rd_ent;
    entry_t        wr_ent;
    logic          cmd_fire;
    logic [WW-1:0] req_w, need_w, ent_size_w, ent_off_w;
    logic [WW-1:0] grow_w, brk_w, new_brk_w, gblk_w;
    logic [XW-1:0] count_x, idx_x, hit_x, sh_x;
    logic          alloc_fit, off_hit, match, split_ok, grow_split;

    assign rd_ent    = entry_t'(rd_data);
    assign wr_data   = wr_ent;
    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign done      = (state_reg == S_DONE);
    assign result    = res_reg;

    // size arithmetic on the request, the entry just read and the heap break
    assign req_w      = WW'(req_reg);
    assign need_w     = req_w + WW'(HEADER_BYTES) + WW'(MIN_BLOCK_BYTES);
    assign ent_size_w = WW'(rd_ent.size);
    assign ent_off_w  = WW'(rd_ent.start) + WW'(HEADER_BYTES);
    assign grow_w     = ((req_w + WW'(HEADER_BYTES) + WW'(PAGE_BYTES - 1)) >> PS) << PS;
    assign brk_w      = WW'(brk_reg);
    assign new_brk_w  = brk_w + grow_w;
    assign gblk_w     = grow_w - WW'(HEADER_BYTES);

    assign count_x = XW'(count_reg);
    assign idx_x   = XW'(idx_reg);
    assign hit_x   = XW'(hit_reg);
    assign sh_x    = XW'(sh_reg);

    assign alloc_fit  = rd_ent.free && (ent_size_w >= req_w);
    assign off_hit    = (ent_off_w == WW'(off_reg));
    assign match      = (op_reg == ACT_ALLOC) ? alloc_fit : off_hit;
    assign split_ok   = (req_reg != '0) && (count_reg < CW'(MAX_BLOCKS))
                        && (ent_size_w >= need_w);
    assign grow_split = (req_reg != '0) && ((count_x + XW'(1)) < XW'(MAX_BLOCKS))
                        && (gblk_w >= need_w);

    // sequence one request through the table
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        up_next    = up_reg;
        op_next    = op_reg;
        req_next   = req_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        sh_next    = sh_reg;
        stop_next  = stop_reg;
        count_next = count_reg;
        brk_next   = brk_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        prev_next  = prev_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = idx_reg[IW-1:0];
        wr_en      = 1'b0;
        wr_addr    = hit_reg[IW-1:0];
        wr_ent     = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next   = cmd.action;
                    req_next  = cmd.request_size;
                    off_next  = cmd.data_offset;
                    idx_next  = '0;
                    prev_next = '0;
                    res_next  = '0;
                    case (cmd.action) inside
                        ACT_ALLOC:
                        begin
                            state_next = (count_reg == '0) ? S_GROW : S_SCAN_RD;
                        end
                        ACT_FREE, ACT_QUERY:
                        begin
                            if ((cmd.data_offset == '0) || (count_reg == '0))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg[IW-1:0];
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (match)
                begin
                    hit_next = idx_reg;
                    case (op_reg)
                        ACT_ALLOC:
                        begin
                            res_next.result_offset = 16'(ent_off_w);
                            if (split_ok)
                            begin
                                head_next  = '{free: 1'b0, size: AW'(req_reg),
                                               start: rd_ent.start};
                                tail_next  = '{free: 1'b1,
                                               size: AW'(ent_size_w - req_w
                                                         - WW'(HEADER_BYTES)),
                                               start: AW'(ent_off_w + req_w)};
                                count_next = count_reg + CW'(1);
                                if ((idx_x + XW'(1)) < count_x)
                                begin
                                    sh_next    = count_reg - CW'(1);
                                    stop_next  = idx_reg + CW'(1);
                                    up_next    = 1'b1;
                                    ret_next   = S_WR_TAIL;
                                    state_next = S_SHIFT_RD;
                                end
                                else
                                begin
                                    state_next = S_WR_TAIL;
                                end
                            end
                            else
                            begin
                                head_next  = '{free: 1'b0, size: rd_ent.size,
                                               start: rd_ent.start};
                                state_next = S_WR_HEAD;
                            end
                        end
                        ACT_FREE:
                        begin
                            head_next  = '{free: 1'b1, size: rd_ent.size,
                                           start: rd_ent.start};
                            state_next = ((idx_x + XW'(1)) < count_x) ? S_NEXT_RD
                                                                      : S_MERGE_PREV;
                        end
                        default:
                        begin
                            res_next.block_bytes = 17'(rd_ent.size);
                            state_next           = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    prev_next = rd_ent;
                    idx_next  = idx_reg + CW'(1);
                    if ((idx_x + XW'(1)) == count_x)
                    begin
                        state_next = (op_reg == ACT_ALLOC) ? S_GROW : S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_GROW:
            begin
                if ((count_reg >= CW'(MAX_BLOCKS)) || (new_brk_w >= WW'(HEAP_BYTES)))
                begin
                    res_next.failed = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    hit_next               = count_reg;
                    brk_next               = AW'(new_brk_w);
                    res_next.result_offset = 16'(brk_w + WW'(HEADER_BYTES));
                    res_next.pages_added   = 5'(grow_w >> PS);
                    if (grow_split)
                    begin
                        head_next  = '{free: 1'b0, size: AW'(req_reg), start: brk_reg};
                        tail_next  = '{free: 1'b1,
                                       size: AW'(gblk_w - req_w - WW'(HEADER_BYTES)),
                                       start: AW'(brk_w + WW'(HEADER_BYTES) + req_w)};
                        count_next = count_reg + CW'(2);
                        state_next = S_WR_TAIL;
                    end
                    else
                    begin
                        head_next  = '{free: 1'b0, size: AW'(gblk_w), start: brk_reg};
                        count_next = count_reg + CW'(1);
                        state_next = S_WR_HEAD;
                    end
                end
            end
            S_NEXT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = IW'(hit_x + XW'(1));
                state_next = S_NEXT_CHK;
            end
            S_NEXT_CHK:
            begin
                state_next = S_MERGE_PREV;
                if (rd_ent.free)
                begin
                    head_next.size = AW'(WW'(head_reg.size) + WW'(HEADER_BYTES)
                                         + ent_size_w);
                    if ((hit_x + XW'(2)) < count_x)
                    begin
                        sh_next    = hit_reg + CW'(1);
                        stop_next  = count_reg - CW'(2);
                        up_next    = 1'b0;
                        ret_next   = S_MERGE_PREV;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_MERGE_PREV:
            begin
                wr_en   = 1'b1;
                wr_addr = hit_reg[IW-1:0];
                wr_ent  = head_reg;
                if ((hit_reg != '0) && prev_reg.free)
                begin
                    prev_next.size = AW'(WW'(prev_reg.size) + WW'(HEADER_BYTES)
                                         + WW'(head_reg.size));
                    state_next     = S_PREV_WR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PREV_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = IW'(hit_x - XW'(1));
                wr_ent  = prev_reg;
                if ((hit_x + XW'(1)) < count_x)
                begin
                    sh_next    = hit_reg;
                    stop_next  = count_reg - CW'(2);
                    up_next    = 1'b0;
                    ret_next   = S_DONE;
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_SHIFT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = up_reg ? sh_reg[IW-1:0] : IW'(sh_x + XW'(1));
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = up_reg ? IW'(sh_x + XW'(1)) : sh_reg[IW-1:0];
                wr_ent  = rd_ent;
                if (sh_reg == stop_reg)
                begin
                    if (!up_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = ret_reg;
                end
                else
                begin
                    sh_next    = up_reg ? (sh_reg - CW'(1)) : (sh_reg + CW'(1));
                    state_next = S_SHIFT_RD;
                end
            end
            S_WR_TAIL:
            begin
                wr_en      = 1'b1;
                wr_addr    = IW'(hit_x + XW'(1));
                wr_ent     = tail_reg;
                state_next = S_WR_HEAD;
            end
            S_WR_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = hit_reg[IW-1:0];
                wr_ent     = head_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_DONE;
            up_reg    <= 1'b0;
            count_reg <= '0;
            brk_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            up_reg    <= up_next;
            count_reg <= count_next;
            brk_reg   <= brk_next;
        end
    end

    // request and working payload
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        req_reg  <= req_next;
        off_reg  <= off_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        sh_reg   <= sh_next;
        stop_reg <= stop_next;
        head_reg <= head_next;
        tail_reg <= tail_next;
        prev_reg <= prev_next;
        res_reg  <= res_next;
    end

    `FFHA_NEVER(a_count_max, count_reg > CW'(MAX_BLOCKS), "block count over table size")
    `FFHA_NEVER(a_break_max, brk_reg >= AW'(HEAP_BYTES), "break reached heap end")
    `FFHA_NEVER(a_rw_clash, rd_en && wr_en && (rd_addr == wr_addr), "read and write same entry")
    `FFHA_ASSERT(a_leave_idle, cmd_fire |=> (state_reg != S_IDLE), "request not started")
    `FFHA_ASSERT(a_hold_done, (state_reg == S_DONE) && !slot_free |=> (state_reg == S_DONE), "result dropped")
endmodule

// ----- hdl/first_fit_heap_allocator_unit.sv -----
// Top level of the first-fit heap allocator with coalescing.
// One request is handled at a time against an address-ordered block table held
// in a single-port-read, single-port-write memory with a registered read port.
// The first-fit or offset search reads and checks each table entry in turn, a
// split or a merge moves the entries behind it one by one, read then write, and
// the request ends with the writes of the new or changed entries, all set by the
// sequential walk over the table memory. No clearing pass is run after reset.
// The next request is taken once the previous result sits in the output register.
`timescale 1ns / 1ps
module first_fit_heap_allocator_unit #(
    parameter int HEAP_BYTES      = ffha_pkg::DEF_HEAP_BYTES,
    parameter int PAGE_BYTES      = ffha_pkg::DEF_PAGE_BYTES,
    parameter int HEADER_BYTES    = ffha_pkg::DEF_HEADER_BYTES,
    parameter int MIN_BLOCK_BYTES = ffha_pkg::DEF_MIN_BLOCK_BYTES,
    parameter int MAX_BLOCKS      = ffha_pkg::DEF_MAX_BLOCKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ffha_pkg::in_item_t  cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output ffha_pkg::out_item_t res
);
    import ffha_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int AW = $clog2(HEAP_BYTES + 1);
    localparam int EW = 2 * AW + 1;

    logic          done;
    logic          slot_free;
    out_item_t     result;
    logic          rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;
    logic          res_valid_reg, res_valid_next;
    out_item_t     res_reg;

    assign slot_free = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    ffha_ctrl #(
        .HEAP_BYTES      (HEAP_BYTES),
        .PAGE_BYTES      (PAGE_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .MAX_BLOCKS      (MAX_BLOCKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .done      (done),
        .slot_free (slot_free),
        .result    (result),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ffha_mem #(
        .DEPTH (MAX_BLOCKS),
        .EW    (EW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // load a finished result, drop it after its transfer
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (done && slot_free)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // hold result payload
    always_ff @(posedge clk)
    begin
        if (done && slot_free)
        begin
            res_reg <= result;
        end
    end
endmodule

// ----- tb/ffha_checker.sv -----
// Checker for the heap allocator: predicts each result and compares it on transfer.
`timescale 1ns / 1ps
module ffha_checker
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES      = DEF_HEAP_BYTES,
    parameter int PAGE_BYTES      = DEF_PAGE_BYTES,
    parameter int HEADER_BYTES    = DEF_HEADER_BYTES,
    parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
    parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_ready,
    input  in_item_t  cmd,
    input  logic      res_valid,
    input  logic      res_ready,
    input  out_item_t res,
    output int        fail_count,
    output int        pending
);

    // Shadow copy of the block table
    logic [16:0] tbl_start [MAX_BLOCKS];
    logic [16:0] tbl_size  [MAX_BLOCKS];
    logic        tbl_free  [MAX_BLOCKS];
    int          tbl_count;
    int          heap_break;

    out_item_t   expected_results [$];

    assign pending = expected_results.size();

    function automatic int lookup_block(logic [15:0] off);
        if (off == 0)
            return -1;
        for (int i = 0; i < tbl_count; i++)
            if (int'(tbl_start[i]) + HEADER_BYTES == int'(off))
                return i;
        return -1;
    endfunction

    // Carve the tail of a block off into a new free entry when room allows
    function automatic void split_entry(int idx, int want);
        if (want == 0 || tbl_count >= MAX_BLOCKS || idx >= tbl_count)
            return;
        if (int'(tbl_size[idx]) < want + HEADER_BYTES + MIN_BLOCK_BYTES)
            return;
        for (int i = tbl_count; i > idx + 1; i--)
        begin
            tbl_start[i] = tbl_start[i-1];
            tbl_size[i]  = tbl_size[i-1];
            tbl_free[i]  = tbl_free[i-1];
        end
        tbl_start[idx+1] = 17'(int'(tbl_start[idx]) + HEADER_BYTES + want);
        tbl_size[idx+1]  = 17'(int'(tbl_size[idx]) - want - HEADER_BYTES);
        tbl_free[idx+1]  = 1'b1;
        tbl_size[idx]    = 17'(want);
        tbl_count++;
    endfunction

    // Fold a free successor into a free block and close the gap
    function automatic void fold_successor(int idx);
        if (idx + 1 >= tbl_count)
            return;
        if (!tbl_free[idx] || !tbl_free[idx+1])
            return;
        tbl_size[idx] = 17'(int'(tbl_size[idx]) + HEADER_BYTES + int'(tbl_size[idx+1]));
        for (int i = idx + 1; i + 1 < tbl_count; i++)
        begin
            tbl_start[i] = tbl_start[i+1];
            tbl_size[i]  = tbl_size[i+1];
            tbl_free[i]  = tbl_free[i+1];
        end
        tbl_count--;
    endfunction

    function automatic out_item_t apply_request(in_item_t it);
        out_item_t r;
        int        req;
        int        k;
        int        np;
        int        grow;
        bit        found;
        r     = '0;
        req   = int'(it.request_size);
        found = 0;
        case (it.action)
            ACT_ALLOC:
            begin
                for (int i = 0; i < tbl_count && !found; i++)
                begin
                    if (tbl_free[i] && int'(tbl_size[i]) >= req)
                    begin
                        split_entry(i, req);
                        tbl_free[i]     = 1'b0;
                        r.result_offset = 16'(int'(tbl_start[i]) + HEADER_BYTES);
                        found           = 1;
                    end
                end
                if (!found)
                begin
                    np   = (req + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
                    grow = np * PAGE_BYTES;
                    if (tbl_count >= MAX_BLOCKS || heap_break + grow >= HEAP_BYTES)
                    begin
                        r.failed = 1'b1;
                    end
                    else
                    begin
                        k            = tbl_count;
                        tbl_start[k] = 17'(heap_break);
                        tbl_size[k]  = 17'(grow - HEADER_BYTES);
                        tbl_free[k]  = 1'b1;
                        tbl_count++;
                        heap_break += grow;
                        split_entry(k, req);
                        tbl_free[k]     = 1'b0;
                        r.result_offset = 16'(int'(tbl_start[k]) + HEADER_BYTES);
                        r.pages_added   = 5'(np);
                    end
                end
            end
            ACT_FREE:
            begin
                k = lookup_block(it.data_offset);
                if (k >= 0)
                begin
                    tbl_free[k] = 1'b1;
                    fold_successor(k);
                    if (k > 0)
                        fold_successor(k - 1);
                end
            end
            ACT_QUERY:
            begin
                k = lookup_block(it.data_offset);
                if (k >= 0)
                    r.block_bytes = tbl_size[k];
            end
            default: ;
        endcase
        return r;
    endfunction

    // Predict on command transfer, compare on result transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_count  = 0;
            heap_break = 0;
            for (int i = 0; i < MAX_BLOCKS; i++)
                tbl_free[i] = 1'b0;
            expected_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result off=%h fail=%b pages=%0d bytes=%0d",
                             $time, res.result_offset, res.failed, res.pages_added,
                             res.block_bytes);
                    fail_count++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e.result_offset !== res.result_offset || e.failed !== res.failed ||
                        e.pages_added !== res.pages_added ||
                        e.block_bytes !== res.block_bytes)
                    begin
                        $display("%0t: expected off=%h fail=%b pages=%0d bytes=%0d, got off=%h fail=%b pages=%0d bytes=%0d",
                                 $time, e.result_offset, e.failed, e.pages_added,
                                 e.block_bytes, res.result_offset, res.failed,
                                 res.pages_added, res.block_bytes);
                        fail_count++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                expected_results.push_back(apply_request(cmd));
        end
    end

endmodule

// ----- tb/tb_first_fit_heap_allocator_unit.sv -----
// Stimulus and verdict for the first-fit heap allocator.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator_unit;
    import ffha_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    in_item_t  cmd;
    logic      res_valid;
    logic      res_ready;
    out_item_t res;
    int        fail_count;
    int        pending;

    int        send_idle_pct;
    int        recv_stall_pct;
    logic [1:0] sent_actions [$];
    int        live_offsets [$];

    first_fit_heap_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    ffha_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result side at random
    always @(negedge clk)
        res_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Track offsets handed out, to aim frees and queries at live blocks
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready && sent_actions.size() > 0)
        begin
            if (sent_actions.pop_front() == ACT_ALLOC && res.result_offset != 0)
                live_offsets.push_back(int'(res.result_offset));
        end
        if (rst_n && cmd_valid && cmd_ready)
            sent_actions.push_back(cmd.action);
    end

    // Present one item and hold it until transfer; returns at the next falling edge
    task automatic send_item(logic [1:0] act, int req, int off);
        in_item_t it;
        it.action       = act;
        it.request_size = 17'(req);
        it.data_offset  = 16'(off);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
    endtask

    // Hold off until every expected result has come back
    task automatic drain;
        cmd_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic int pick_live(bit take);
        int j;
        int o;
        if (live_offsets.size() == 0)
            return $urandom_range(65535);
        j = $urandom_range(live_offsets.size() - 1);
        o = live_offsets[j];
        if (take)
            live_offsets.delete(j);
        return o;
    endfunction

    initial
    begin
        int  r;
        int  sz;
        int  o;
        int  alloc_pct;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        res_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero request, exact page, growth limit, unknown and repeated free
        send_item(ACT_QUERY, 0, 20);
        send_item(ACT_FREE, 0, 0);
        send_item(ACT_ALLOC, 0, 0);
        send_item(ACT_ALLOC, 1, 0);
        send_item(ACT_ALLOC, 4076, 0);
        send_item(ACT_ALLOC, 65536, 16'hFFFF);
        send_item(ACT_ALLOC, 60000, 0);
        send_item(ACT_UNDEF, 17'h1FFFF, 16'hFFFF);
        drain();
        send_item(ACT_QUERY, 0, pick_live(0));
        send_item(ACT_QUERY, 0, 0);
        send_item(ACT_QUERY, 17'h1FFFF, 16'hFFFF);
        o = pick_live(1);
        send_item(ACT_FREE, 0, o);
        send_item(ACT_FREE, 0, o);
        send_item(ACT_QUERY, 0, o);
        send_item(ACT_FREE, 0, 12345);
        send_item(ACT_ALLOC, 0, 0);
        send_item(ACT_ALLOC, 16, 0);
        send_item(ACT_ALLOC, 2000, 0);
        drain();
        while (live_offsets.size() > 0)
            send_item(ACT_FREE, 0, pick_live(1));
        send_item(ACT_ALLOC, 300, 0);
        drain();

        // Random: mostly allocate/free/query on live blocks, some noise
        for (int n = 0; n < 1600; n++)
        begin
            case ((n / 100) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            alloc_pct = ((n / 200) % 3 == 1) ? 75 : 45;
            if (n % 400 == 399)
                drain();
            r = $urandom_range(99);
            if (r < alloc_pct)
            begin
                case ($urandom_range(19))
                    0:       sz = 0;
                    1:       sz = $urandom_range(4096, 12000);
                    2:       sz = $urandom_range(131071);
                    3, 4:    sz = $urandom_range(600, 4096);
                    default: sz = $urandom_range(1, 256);
                endcase
                send_item(ACT_ALLOC, sz, $urandom_range(65535));
            end
            else if (r < alloc_pct + 30)
            begin
                if ($urandom_range(9) == 0)
                    send_item(ACT_FREE, $urandom_range(131071), pick_live(0));
                else if ($urandom_range(9) == 0)
                    send_item(ACT_FREE, 0, $urandom_range(65535));
                else
                    send_item(ACT_FREE, $urandom_range(131071), pick_live(1));
            end
            else if (r < 97)
            begin
                o = ($urandom_range(4) == 0) ? $urandom_range(65535) : pick_live(0);
                send_item(ACT_QUERY, $urandom_range(131071), o);
            end
            else
            begin
                send_item(ACT_UNDEF, $urandom_range(131071), $urandom_range(65535));
            end
        end

        drain();
        repeat (300) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Give up after a generous bound
    initial
    begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
